@@ design/bts_pkg.sv @@
// Shared types and constants for the bilinear texture sampler.
// Used by bts_texel_mem and bilinear_texture_sampler; depends on nothing.
package bts_pkg;

  // Texel store geometry: 24-bit RGB, R in the top byte
  localparam int TEXEL_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int STORE_ADDR_W = 16;
  localparam int STORE_DEPTH  = 65536;

  // Coordinates are unsigned Q1.16
  localparam int COORD_W = 17;
  localparam logic [COORD_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [COORD_W-1:0] HALF_Q16 = 17'd32768;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0]  REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_TEX_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET     = 9'd256;

  // Item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Write port of a texel store copy
  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
    logic [TEXEL_W-1:0]      data;
  } mem_wr_t;

endpackage

@@ design/bts_texel_mem.sv @@
// One copy of the texel store: one write port, two registered read ports.
// Depends on bts_pkg for geometry and the write port struct.
module bts_texel_mem (
  input  logic                             clk,
  input  bts_pkg::mem_wr_t                 wr,
  input  logic                             rd_en,
  input  logic [bts_pkg::STORE_ADDR_W-1:0] rd_addr_a,
  input  logic [bts_pkg::STORE_ADDR_W-1:0] rd_addr_b,
  output logic [bts_pkg::TEXEL_W-1:0]      rd_data_a,
  output logic [bts_pkg::TEXEL_W-1:0]      rd_data_b
);

  logic [bts_pkg::TEXEL_W-1:0] mem [bts_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read ports, data held while the reading stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ design/bilinear_texture_sampler.sv @@
// Bilinear texture sampler, clamp-to-edge, RGB8 texel store.
// A sample result passes the stage 1 to stage 5 registers and then the output register.
// Throughput: one item per cycle while the result side does not stall; the four
// texel reads come from two copies of the store, each with two read ports.
// Reset clears the pipeline, holds off items and config, sets both sizes to 256
// (limited to MAX_DIM); the texel store is not cleared, undefined until written.
module bilinear_texture_sampler #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic                              cmd,
  input  logic [bts_pkg::STORE_ADDR_W-1:0]  texel_addr,
  input  logic [bts_pkg::CHAN_W-1:0]        texel_red,
  input  logic [bts_pkg::CHAN_W-1:0]        texel_green,
  input  logic [bts_pkg::CHAN_W-1:0]        texel_blue,
  input  logic [bts_pkg::COORD_W-1:0]       u_coord,
  input  logic [bts_pkg::COORD_W-1:0]       v_coord,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [bts_pkg::CHAN_W-1:0]        red_out,
  output logic [bts_pkg::CHAN_W-1:0]        green_out,
  output logic [bts_pkg::CHAN_W-1:0]        blue_out,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SZ_W   = $clog2(MAX_DIM + 1);
  localparam int IX_W   = $clog2(MAX_DIM);
  localparam int BW     = 16 + SZ_W;
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int ROW_W  = bts_pkg::CHAN_W + FRAC_BITS;
  localparam int ACC_W  = bts_pkg::CHAN_W + 2 * FRAC_BITS;
  localparam int ADR_CW = (IX_W + SZ_W + 1 > bts_pkg::STORE_ADDR_W) ?
                          (IX_W + SZ_W + 1) : bts_pkg::STORE_ADDR_W;
  localparam logic [SZ_W-1:0] SIZE_RST =
    (int'(bts_pkg::SIZE_RESET) > MAX_DIM) ? SZ_W'(MAX_DIM) : SZ_W'(bts_pkg::SIZE_RESET);
  localparam logic [WT_W-1:0] WT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // size register value as used: zero acts as one, large values clip
  function automatic logic [SZ_W-1:0] eff_size(input logic [bts_pkg::CFG_DATA_W-1:0] r);
    if (r == '0) begin
      return SZ_W'(1);
    end else if (32'(r) > MAX_DIM) begin
      return SZ_W'(MAX_DIM);
    end else begin
      return SZ_W'(r);
    end
  endfunction

  function automatic logic [WT_W-1:0] WT_W_ONE_MINUS(input logic [WT_W-1:0] f);
    return WT_ONE - f;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration
  logic [SZ_W-1:0] width_eff;
  logic [SZ_W-1:0] height_eff;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= SIZE_RST;
      height_eff <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bts_pkg::REG_TEX_WIDTH:  width_eff  <= eff_size(cfg_data);
        bts_pkg::REG_TEX_HEIGHT: height_eff <= eff_size(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage advance: a stage loads when it is empty or its contents move on
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic en1, en2, en3, en4, en5, en6;
  logic s3_cmd;

  assign en6 = !result_valid || !result_stall;
  assign en5 = !s5_valid || en6;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign sample_stall = !en1 || rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= sample_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      // write items end at the store
      if (en4) s4_valid <= s3_valid && (s3_cmd == bts_pkg::CMD_SAMPLE);
      if (en5) s5_valid <= s4_valid;
      if (en6) result_valid <= s5_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: capture item, clamp u, clamp and flip v
  logic                             s1_cmd;
  logic [bts_pkg::STORE_ADDR_W-1:0] s1_waddr;
  logic [bts_pkg::TEXEL_W-1:0]      s1_texel;
  logic [bts_pkg::COORD_W-1:0]      s1_u;
  logic [bts_pkg::COORD_W-1:0]      s1_v;
  logic [bts_pkg::COORD_W-1:0]      u_sat;
  logic [bts_pkg::COORD_W-1:0]      v_sat;

  assign u_sat = (u_coord > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : u_coord;
  assign v_sat = (v_coord > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : v_coord;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd   <= cmd;
      s1_waddr <= texel_addr;
      s1_texel <= {texel_red, texel_green, texel_blue};
      s1_u     <= u_sat;
      s1_v     <= bts_pkg::ONE_Q16 - v_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: scale by size and add a half texel (biased so it never goes negative)
  logic                             s2_cmd;
  logic [bts_pkg::STORE_ADDR_W-1:0] s2_waddr;
  logic [bts_pkg::TEXEL_W-1:0]      s2_texel;
  logic [SZ_W-1:0]                  s2_whole_x;
  logic [SZ_W-1:0]                  s2_whole_y;
  logic [FRAC_BITS-1:0]             s2_frac_a;
  logic [FRAC_BITS-1:0]             s2_frac_b;
  logic [BW-1:0]                    biased_x;
  logic [BW-1:0]                    biased_y;

  assign biased_x = BW'(s1_u) * BW'(width_eff)  + BW'(bts_pkg::HALF_Q16);
  assign biased_y = BW'(s1_v) * BW'(height_eff) + BW'(bts_pkg::HALF_Q16);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_cmd     <= s1_cmd;
      s2_waddr   <= s1_waddr;
      s2_texel   <= s1_texel;
      s2_whole_x <= biased_x[BW-1:16];
      s2_whole_y <= biased_y[BW-1:16];
      s2_frac_a  <= biased_x[15 -: FRAC_BITS];
      s2_frac_b  <= biased_y[15 -: FRAC_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: clamp neighbours to the edge, form the four store addresses
  logic [bts_pkg::STORE_ADDR_W-1:0] s3_waddr;
  logic [bts_pkg::TEXEL_W-1:0]      s3_texel;
  logic [FRAC_BITS-1:0]             s3_frac_a;
  logic [FRAC_BITS-1:0]             s3_frac_b;
  logic [bts_pkg::STORE_ADDR_W-1:0] s3_addr00, s3_addr10, s3_addr01, s3_addr11;

  logic [SZ_W-1:0]   w_m1, h_m1;
  logic [SZ_W-1:0]   x0_raw, y0_raw, x0_cl, y0_cl, x1_cl, y1_cl;
  logic [IX_W-1:0]   x0, x1, y0, y1;
  logic [ADR_CW-1:0] row0_base, row1_base;
  logic [ADR_CW-1:0] a00, a10, a01, a11;

  always_comb begin
    w_m1   = width_eff - SZ_W'(1);
    h_m1   = height_eff - SZ_W'(1);
    // floor of -1 rounds up to the first texel
    x0_raw = (s2_whole_x == '0) ? '0 : s2_whole_x - SZ_W'(1);
    y0_raw = (s2_whole_y == '0) ? '0 : s2_whole_y - SZ_W'(1);
    x0_cl  = (x0_raw > w_m1) ? w_m1 : x0_raw;
    y0_cl  = (y0_raw > h_m1) ? h_m1 : y0_raw;
    x1_cl  = (s2_whole_x > w_m1) ? w_m1 : s2_whole_x;
    y1_cl  = (s2_whole_y > h_m1) ? h_m1 : s2_whole_y;
    x0     = x0_cl[IX_W-1:0];
    x1     = x1_cl[IX_W-1:0];
    y0     = y0_cl[IX_W-1:0];
    y1     = y1_cl[IX_W-1:0];
    // row-major, wrapping at the store depth
    row0_base = ADR_CW'(y0) * ADR_CW'(width_eff);
    row1_base = ADR_CW'(y1) * ADR_CW'(width_eff);
    a00 = row0_base + ADR_CW'(x0);
    a10 = row0_base + ADR_CW'(x1);
    a01 = row1_base + ADR_CW'(x0);
    a11 = row1_base + ADR_CW'(x1);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_cmd    <= s2_cmd;
      s3_waddr  <= s2_waddr;
      s3_texel  <= s2_texel;
      s3_frac_a <= s2_frac_a;
      s3_frac_b <= s2_frac_b;
      s3_addr00 <= a00[bts_pkg::STORE_ADDR_W-1:0];
      s3_addr10 <= a10[bts_pkg::STORE_ADDR_W-1:0];
      s3_addr01 <= a01[bts_pkg::STORE_ADDR_W-1:0];
      s3_addr11 <= a11[bts_pkg::STORE_ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: texel store access. Writes and reads both happen on the move
  // from stage 3, in item order, so a sample always sees earlier writes.
  bts_pkg::mem_wr_t            store_wr;
  logic [bts_pkg::TEXEL_W-1:0] t00, t10, t01, t11;
  logic [FRAC_BITS-1:0]        s4_frac_a;
  logic [FRAC_BITS-1:0]        s4_frac_b;

  always_comb begin
    store_wr.en   = en4 && s3_valid && (s3_cmd == bts_pkg::CMD_WRITE);
    store_wr.addr = s3_waddr;
    store_wr.data = s3_texel;
  end

  // top row copy
  bts_texel_mem u_store_row0 (
    .clk       (clk),
    .wr        (store_wr),
    .rd_en     (en4),
    .rd_addr_a (s3_addr00),
    .rd_addr_b (s3_addr10),
    .rd_data_a (t00),
    .rd_data_b (t10)
  );

  // bottom row copy
  bts_texel_mem u_store_row1 (
    .clk       (clk),
    .wr        (store_wr),
    .rd_en     (en4),
    .rd_addr_a (s3_addr01),
    .rd_addr_b (s3_addr11),
    .rd_data_a (t01),
    .rd_data_b (t11)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_frac_a <= s3_frac_a;
      s4_frac_b <= s3_frac_b;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: lerp along u for both rows, each channel
  logic [ROW_W-1:0]     s5_row0 [3];
  logic [ROW_W-1:0]     s5_row1 [3];
  logic [FRAC_BITS-1:0] s5_frac_b;
  logic [ROW_W-1:0]     row0_n [3];
  logic [ROW_W-1:0]     row1_n [3];
  logic [WT_W-1:0]      wa, wa_inv;
  logic [ROW_W:0]       sum0 [3];
  logic [ROW_W:0]       sum1 [3];

  always_comb begin
    wa     = WT_W'(s4_frac_a);
    wa_inv = WT_W_ONE_MINUS(wa);
    for (int k = 0; k < 3; k++) begin
      sum0[k] = (ROW_W+1)'(t00[bts_pkg::TEXEL_W-1-8*k -: 8]) * (ROW_W+1)'(wa_inv)
              + (ROW_W+1)'(t10[bts_pkg::TEXEL_W-1-8*k -: 8]) * (ROW_W+1)'(wa);
      sum1[k] = (ROW_W+1)'(t01[bts_pkg::TEXEL_W-1-8*k -: 8]) * (ROW_W+1)'(wa_inv)
              + (ROW_W+1)'(t11[bts_pkg::TEXEL_W-1-8*k -: 8]) * (ROW_W+1)'(wa);
      row0_n[k] = sum0[k][ROW_W-1:0];
      row1_n[k] = sum1[k][ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_frac_b <= s4_frac_b;
      for (int k = 0; k < 3; k++) begin
        s5_row0[k] <= row0_n[k];
        s5_row1[k] <= row1_n[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: lerp along v, truncate to 8 bits into the output register
  logic [WT_W-1:0]  wb, wb_inv;
  logic [ACC_W:0]   acc [3];

  always_comb begin
    wb     = WT_W'(s5_frac_b);
    wb_inv = WT_W_ONE_MINUS(wb);
    for (int k = 0; k < 3; k++) begin
      acc[k] = (ACC_W+1)'(s5_row0[k]) * (ACC_W+1)'(wb_inv)
             + (ACC_W+1)'(s5_row1[k]) * (ACC_W+1)'(wb);
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      red_out   <= acc[0][2*FRAC_BITS +: bts_pkg::CHAN_W];
      green_out <= acc[1][2*FRAC_BITS +: bts_pkg::CHAN_W];
      blue_out  <= acc[2][2*FRAC_BITS +: bts_pkg::CHAN_W];
    end
  end

endmodule

@@ dv/tb_bilinear_texture_sampler.sv @@
// Self-checking testbench for bilinear_texture_sampler: texel writes, samples and size registers.
// It holds its own bilinear predictor and a copy of the texel store.
// Depends on bts_pkg and the bilinear_texture_sampler RTL only.
`timescale 1ns / 100ps

module tb_bilinear_texture_sampler;

  localparam int MAX_DIM        = 256;
  localparam int FRAC_BITS      = 8;
  localparam int PIPE_LATENCY   = 5;
  localparam int DRAIN_TAIL     = PIPE_LATENCY + 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 60;
  // index with no register behind it
  localparam logic [bts_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [bts_pkg::CHAN_W-1:0] r;
    logic [bts_pkg::CHAN_W-1:0] g;
    logic [bts_pkg::CHAN_W-1:0] b;
  } rgb_t;

  // four store addresses (x0y0, x1y0, x0y1, x1y1) and the two blend fractions
  typedef struct packed {
    logic [3:0][bts_pkg::STORE_ADDR_W-1:0] addr;
    logic [FRAC_BITS-1:0]                  fu;
    logic [FRAC_BITS-1:0]                  fv;
  } footprint_t;

  logic                             clk;
  logic                             rst;
  logic                             sample_valid;
  logic                             sample_stall;
  logic                             cmd;
  logic [bts_pkg::STORE_ADDR_W-1:0] texel_addr;
  logic [bts_pkg::CHAN_W-1:0]       texel_red;
  logic [bts_pkg::CHAN_W-1:0]       texel_green;
  logic [bts_pkg::CHAN_W-1:0]       texel_blue;
  logic [bts_pkg::COORD_W-1:0]      u_coord;
  logic [bts_pkg::COORD_W-1:0]      v_coord;
  logic                             result_valid;
  logic                             result_stall;
  logic [bts_pkg::CHAN_W-1:0]       red_out;
  logic [bts_pkg::CHAN_W-1:0]       green_out;
  logic [bts_pkg::CHAN_W-1:0]       blue_out;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [bts_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [bts_pkg::CFG_DATA_W-1:0]   cfg_data;

  // predictor state: texel store copy, which entries hold data, size registers
  logic [bts_pkg::TEXEL_W-1:0]    texel_copy [0:bts_pkg::STORE_DEPTH-1];
  bit                             texel_written [0:bts_pkg::STORE_DEPTH-1];
  logic [bts_pkg::CFG_DATA_W-1:0] width_reg  = bts_pkg::SIZE_RESET;
  logic [bts_pkg::CFG_DATA_W-1:0] height_reg = bts_pkg::SIZE_RESET;

  rgb_t expected_rgb [$];
  int   fail_count = 0;
  int   items_taken = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  // long holds: the test side counts requests, the receiver counts those served
  int   hold_asked = 0;
  int   hold_served = 0;
  int   hold_left = 0;

  bilinear_texture_sampler #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .cmd         (cmd),
    .texel_addr  (texel_addr),
    .texel_red   (texel_red),
    .texel_green (texel_green),
    .texel_blue  (texel_blue),
    .u_coord     (u_coord),
    .v_coord     (v_coord),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // zero acts as one, anything past MAX_DIM is limited to it
  function automatic int unsigned eff_size(input logic [bts_pkg::CFG_DATA_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return 32'(r);
  endfunction

  // coord*size - 1/2 split into clamped neighbours and a fraction
  function automatic void split_axis(input int unsigned coord, input int unsigned size,
                                     output int unsigned lo, output int unsigned hi,
                                     output int unsigned frac);
    longint unsigned biased;
    longint unsigned whole;
    biased = 64'(coord) * 64'(size) + 64'(bts_pkg::HALF_Q16);   // biased up by one texel
    whole  = biased >> 16;
    frac   = 32'((biased & 64'hFFFF) >> (16 - FRAC_BITS));
    lo = (whole == 0) ? 0 : 32'(whole - 1);
    if (lo >= size) lo = size - 1;
    hi = (whole >= size) ? size - 1 : 32'(whole);
  endfunction

  function automatic footprint_t locate(input logic [bts_pkg::COORD_W-1:0] u_in,
                                        input logic [bts_pkg::COORD_W-1:0] v_in);
    logic [bts_pkg::COORD_W-1:0] u;
    logic [bts_pkg::COORD_W-1:0] v;
    int unsigned w, h, x0, x1, y0, y1, fu, fv;
    footprint_t fp;
    // saturate above one, then flip v
    u = (u_in > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : u_in;
    v = (v_in > bts_pkg::ONE_Q16) ? bts_pkg::ONE_Q16 : v_in;
    v = bts_pkg::ONE_Q16 - v;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    split_axis(32'(u), w, x0, x1, fu);
    split_axis(32'(v), h, y0, y1, fv);
    // row-major, wrapping at the store depth
    fp.addr[0] = bts_pkg::STORE_ADDR_W'(y0 * w + x0);
    fp.addr[1] = bts_pkg::STORE_ADDR_W'(y0 * w + x1);
    fp.addr[2] = bts_pkg::STORE_ADDR_W'(y1 * w + x0);
    fp.addr[3] = bts_pkg::STORE_ADDR_W'(y1 * w + x1);
    fp.fu = FRAC_BITS'(fu);
    fp.fv = FRAC_BITS'(fv);
    return fp;
  endfunction

  // lerp along u, then along v, truncate
  function automatic logic [bts_pkg::CHAN_W-1:0] blend(input logic [bts_pkg::CHAN_W-1:0] t00,
                                                       input logic [bts_pkg::CHAN_W-1:0] t10,
                                                       input logic [bts_pkg::CHAN_W-1:0] t01,
                                                       input logic [bts_pkg::CHAN_W-1:0] t11,
                                                       input longint unsigned a,
                                                       input longint unsigned b);
    longint unsigned wt, row0, row1, acc;
    wt   = 64'(1) << FRAC_BITS;
    row0 = 64'(t00) * (wt - a) + 64'(t10) * a;
    row1 = 64'(t01) * (wt - a) + 64'(t11) * a;
    acc  = row0 * (wt - b) + row1 * b;
    return bts_pkg::CHAN_W'(acc >> (2 * FRAC_BITS));
  endfunction

  function automatic rgb_t filtered_colour(input logic [bts_pkg::COORD_W-1:0] u,
                                           input logic [bts_pkg::COORD_W-1:0] v);
    footprint_t fp;
    logic [3:0][bts_pkg::TEXEL_W-1:0] t;
    rgb_t res;
    int k;
    fp = locate(u, v);
    for (k = 0; k < 4; k++) t[k] = texel_copy[fp.addr[k]];
    res.r = blend(t[0][23:16], t[1][23:16], t[2][23:16], t[3][23:16],
                  64'(fp.fu), 64'(fp.fv));
    res.g = blend(t[0][15:8], t[1][15:8], t[2][15:8], t[3][15:8],
                  64'(fp.fu), 64'(fp.fv));
    res.b = blend(t[0][7:0], t[1][7:0], t[2][7:0], t[3][7:0],
                  64'(fp.fu), 64'(fp.fv));
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  // offer one item; on acceptance update the store copy or queue the colour
  task automatic send_item(input logic op, input logic [bts_pkg::STORE_ADDR_W-1:0] addr,
                           input logic [bts_pkg::TEXEL_W-1:0] rgb,
                           input logic [bts_pkg::COORD_W-1:0] u,
                           input logic [bts_pkg::COORD_W-1:0] v);
    if ($urandom_range(99) < tx_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    sample_valid <= 1'b1;
    cmd          <= op;
    texel_addr   <= addr;
    texel_red    <= rgb[23:16];
    texel_green  <= rgb[15:8];
    texel_blue   <= rgb[7:0];
    u_coord      <= u;
    v_coord      <= v;
    do @(posedge clk); while (sample_stall);
    items_taken++;
    if (op == bts_pkg::CMD_WRITE) begin
      texel_copy[addr]    = rgb;
      texel_written[addr] = 1'b1;
    end else begin
      expected_rgb.push_back(filtered_colour(u, v));
    end
  endtask

  task automatic send_write(input logic [bts_pkg::STORE_ADDR_W-1:0] addr,
                            input logic [bts_pkg::TEXEL_W-1:0] rgb);
    send_item(bts_pkg::CMD_WRITE, addr, rgb,
              bts_pkg::COORD_W'($urandom), bts_pkg::COORD_W'($urandom));
  endtask

  // fill any of the four texels not yet written, then sample
  task automatic send_sample(input logic [bts_pkg::COORD_W-1:0] u,
                             input logic [bts_pkg::COORD_W-1:0] v);
    footprint_t fp;
    int k;
    fp = locate(u, v);
    for (k = 0; k < 4; k++)
      if (!texel_written[fp.addr[k]]) send_write(fp.addr[k], bts_pkg::TEXEL_W'($urandom));
    send_item(bts_pkg::CMD_SAMPLE, bts_pkg::STORE_ADDR_W'($urandom),
              bts_pkg::TEXEL_W'($urandom), u, v);
  endtask

  // mostly in range, with edges and values above one mixed in
  function automatic logic [bts_pkg::COORD_W-1:0] random_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return bts_pkg::ONE_Q16;
      2: return bts_pkg::COORD_W'($urandom_range(131071, 65537));
      default: return bts_pkg::COORD_W'($urandom_range(65536, 0));
    endcase
  endfunction

  task automatic send_random_item();
    if ($urandom_range(5) == 0)
      send_write(bts_pkg::STORE_ADDR_W'($urandom), bts_pkg::TEXEL_W'($urandom));
    else
      send_sample(random_coord(), random_coord());
  endtask

  // leaves cfg_valid high; the caller lowers it
  task automatic cfg_put(input logic [bts_pkg::CFG_IDX_W-1:0] idx,
                         input logic [bts_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bts_pkg::REG_TEX_WIDTH:  width_reg  = val;
      bts_pkg::REG_TEX_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_texture_size(input logic [bts_pkg::CFG_DATA_W-1:0] w,
                                  input logic [bts_pkg::CFG_DATA_W-1:0] h);
    cfg_put(bts_pkg::REG_TEX_WIDTH, w);
    cfg_put(bts_pkg::REG_TEX_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every colour, then let trailing writes settle
  task automatic wait_drain();
    sample_valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  // receiver stall: random, or held for a long stretch on request
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_result
    rgb_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_rgb.size() == 0) begin
        $error("unexpected result: red_out %0d green_out %0d blue_out %0d",
               red_out, green_out, blue_out);
        fail_count++;
      end else begin
        want = expected_rgb.pop_front();
        if (red_out !== want.r) begin
          $error("red_out: expected %0d, got %0d", want.r, red_out);
          fail_count++;
        end
        if (green_out !== want.g) begin
          $error("green_out: expected %0d, got %0d", want.g, green_out);
          fail_count++;
        end
        if (blue_out !== want.b) begin
          $error("blue_out: expected %0d, got %0d", want.b, blue_out);
          fail_count++;
        end
      end
    end
  end

  // ends the run if nothing moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // 2x2 texture with extreme colours, sampled at corners, centre and beyond one
  task automatic test_corner_texels();
    set_texture_size(9'd2, 9'd2);
    send_write(16'd0, 24'h000000);
    send_write(16'd1, 24'hFFFFFF);
    send_write(16'd2, 24'hFF0080);
    send_write(16'd3, 24'h00FF01);
    send_write(16'hFFFF, 24'h5AA5C3);
    send_write(16'h5AA5, 24'hA55A3C);
    send_sample(17'd0, 17'd0);
    send_sample(bts_pkg::ONE_Q16, bts_pkg::ONE_Q16);
    send_sample(17'd0, bts_pkg::ONE_Q16);
    send_sample(bts_pkg::ONE_Q16, 17'd0);
    send_sample(bts_pkg::HALF_Q16, bts_pkg::HALF_Q16);
    send_sample(17'd16384, 17'd49152);
    send_sample(17'd131071, 17'd0);
    send_sample(17'd65537, 17'd131071);
    send_sample(17'd12345, 17'd54321);
    wait_drain();
  endtask

  // size registers at zero, one, full and beyond full, plus the spare index
  task automatic test_size_extremes();
    logic [bts_pkg::CFG_DATA_W-1:0] w_list [0:6];
    logic [bts_pkg::CFG_DATA_W-1:0] h_list [0:6];
    int i, n;
    w_list = '{9'd0, 9'd1, 9'd511, 9'd257, 9'd256, 9'd1, 9'd3};
    h_list = '{9'd0, 9'd1, 9'd511, 9'd3, 9'd1, 9'd256, 9'd256};
    cfg_put(REG_SPARE, 9'h1FF);
    for (i = 0; i < 7; i++) begin
      cfg_put(bts_pkg::REG_TEX_WIDTH, w_list[i]);
      cfg_put(bts_pkg::REG_TEX_HEIGHT, h_list[i]);
      cfg_valid <= 1'b0;
      for (n = 0; n < 5; n++) send_sample(random_coord(), random_coord());
      wait_drain();
    end
  endtask

  // random traffic, two size settings per idling mode, mostly small sizes
  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int phase, start;
    logic [bts_pkg::CFG_DATA_W-1:0] w, h;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (phase = 0; phase < 2; phase++) begin
      w = ($urandom_range(7) == 0) ? bts_pkg::CFG_DATA_W'($urandom_range(511, 200))
                                   : bts_pkg::CFG_DATA_W'($urandom_range(12, 1));
      h = ($urandom_range(7) == 0) ? bts_pkg::CFG_DATA_W'($urandom_range(511, 200))
                                   : bts_pkg::CFG_DATA_W'($urandom_range(12, 1));
      set_texture_size(w, h);
      start = items_taken;
      while (items_taken - start < PHASE_ITEMS) send_random_item();
      wait_drain();
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure_fill();
    int n;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_texture_size(9'd8, 9'd8);
    @(negedge clk) hold_asked++;
    @(posedge clk);
    for (n = 0; n < 50; n++) send_sample(random_coord(), random_coord());
    // sender pauses until every colour has come back
    wait_drain();
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    cmd          = bts_pkg::CMD_WRITE;
    texel_addr   = '0;
    texel_red    = '0;
    texel_green  = '0;
    texel_blue   = '0;
    u_coord      = '0;
    v_coord      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_texels();
    test_size_extremes();
    test_random_traffic(23, 67);
    test_random_traffic(67, 23);
    test_random_traffic(0, 0);
    test_backpressure_fill();

    wait_drain();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
